### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

### rtl/frt_pkg.sv
`default_nettype none

package frt_pkg;

    localparam int BUFFER_BYTES       = 256;
    localparam int FRAGMENT_MAX_BYTES = 16;
    localparam int ADDR_W             = $clog2(BUFFER_BYTES);
    localparam int OFS_W              = ADDR_W + 1;
    localparam int QUEUE_DEPTH        = 2;
    localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W             = QPTR_W + 1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    typedef enum logic [2:0] {
        ST_STORED   = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_NO_OPEN  = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_LEAK     = 3'd4,
        ST_TIMEOUT  = 3'd5,
        ST_IDLE     = 3'd6,
        ST_READ     = 3'd7
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [8:0]          len;
        logic                we;
        logic                rd_en;
        logic [ADDR_W-1:0]   addr;
        logic [7:0]          data;
    } t_op;

    typedef struct packed {
        logic push;
        logic pop;
    } t_q_ctl;

endpackage

`default_nettype wire

### rtl/frt_if.sv
`default_nettype none

interface frt_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       frag_first;
    logic       frag_final;
    logic       head_flag;
    logic       tail_flag;
    logic [4:0] frag_bytes;
    logic [7:0] data_byte;
    logic [7:0] read_index;

    modport source (
        output valid, kind, frag_first, frag_final, head_flag, tail_flag,
               frag_bytes, data_byte, read_index,
        input  ready
    );
    modport sink (
        input  valid, kind, frag_first, frag_final, head_flag, tail_flag,
               frag_bytes, data_byte, read_index,
        output ready
    );
endinterface

interface frt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [8:0] message_length;
    logic [7:0] read_data;

    modport source (
        output valid, status, message_length, read_data,
        input  ready
    );
    modport sink (
        input  valid, status, message_length, read_data,
        output ready
    );
endinterface

`default_nettype wire

### rtl/frt_front.sv
`default_nettype none

module frt_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_wr_en,
    input  wire logic [15:0]    i_cfg_wr_data,
    frt_in_if.sink              i_in,
    input  wire logic           i_q_full,
    output logic                o_push,
    output frt_pkg::t_op        o_op
);

    logic                       r_open, n_open;
    logic                       r_dropping, n_dropping;
    logic                       r_drop_ovf, n_drop_ovf;
    logic                       r_active, n_active;
    logic [4:0]                 r_left, n_left;
    logic [frt_pkg::OFS_W-1:0]  r_wofs, n_wofs;
    logic [15:0]                r_idle, n_idle;
    logic [frt_pkg::OFS_W-1:0]  r_clen, n_clen;
    logic [15:0]                r_timeout;

    logic                       accept;
    logic                       leak;
    logic                       store;
    logic                       no_fit;
    logic [frt_pkg::OFS_W-1:0]  wofs_v;
    logic [4:0]                 left_v;
    logic [15:0]                idle_v;
    logic [15:0]                limit;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && !i_q_full;
    assign o_push     = accept;

    always_comb begin
        n_open     = r_open;
        n_dropping = r_dropping;
        n_drop_ovf = r_drop_ovf;
        n_active   = r_active;
        n_left     = r_left;
        n_wofs     = r_wofs;
        n_idle     = r_idle;
        n_clen     = r_clen;
        leak       = 1'b0;
        store      = 1'b0;
        no_fit     = 1'b0;
        wofs_v     = r_wofs;
        left_v     = r_left;
        idle_v     = r_idle;
        limit      = (r_timeout == 16'd0) ? 16'd1 : r_timeout;
        o_op.status = frt_pkg::ST_IDLE;
        o_op.len    = '0;
        o_op.we     = 1'b0;
        o_op.rd_en  = 1'b0;
        o_op.addr   = '0;
        o_op.data   = i_in.data_byte;

        unique case (i_in.kind)
            frt_pkg::KIND_BYTE: begin
                if (i_in.frag_first) begin
                    n_active   = 1'b0;
                    n_dropping = 1'b0;
                    if (i_in.head_flag) begin
                        leak   = r_open;
                        n_open = 1'b1;
                        wofs_v = '0;
                        n_wofs = '0;
                        n_idle = '0;
                    end
                    no_fit = (32'(i_in.frag_bytes) > frt_pkg::FRAGMENT_MAX_BYTES) ||
                             (32'(wofs_v) + 32'(i_in.frag_bytes) > frt_pkg::BUFFER_BYTES);
                    if (!n_open || no_fit) begin
                        n_drop_ovf  = n_open;
                        n_dropping  = !i_in.frag_final;
                        o_op.status = n_open ? frt_pkg::ST_OVERFLOW : frt_pkg::ST_NO_OPEN;
                    end else begin
                        n_active = 1'b1;
                        left_v   = i_in.frag_bytes;
                        store    = 1'b1;
                    end
                end else if (r_dropping) begin
                    if (i_in.frag_final) begin
                        n_dropping = 1'b0;
                    end
                    o_op.status = r_drop_ovf ? frt_pkg::ST_OVERFLOW : frt_pkg::ST_NO_OPEN;
                end else if (!r_active) begin
                    o_op.status = frt_pkg::ST_NO_OPEN;
                end else begin
                    store = 1'b1;
                end

                if (store) begin
                    if ((left_v != 5'd0) && (32'(wofs_v) < frt_pkg::BUFFER_BYTES)) begin
                        o_op.we   = 1'b1;
                        o_op.addr = wofs_v[frt_pkg::ADDR_W-1:0];
                        wofs_v    = wofs_v + 1'b1;
                        left_v    = left_v - 1'b1;
                    end
                    n_wofs      = wofs_v;
                    n_left      = left_v;
                    n_idle      = '0;
                    o_op.status = leak ? frt_pkg::ST_LEAK : frt_pkg::ST_STORED;
                    if (i_in.frag_final) begin
                        n_active = 1'b0;
                        n_left   = '0;
                        if (i_in.tail_flag) begin
                            n_clen      = wofs_v;
                            n_open      = 1'b0;
                            n_wofs      = '0;
                            o_op.status = frt_pkg::ST_COMPLETE;
                            o_op.len    = 9'(wofs_v);
                        end
                    end
                end
            end
            frt_pkg::KIND_TICK: begin
                if (r_open) begin
                    idle_v = (r_idle != 16'hFFFF) ? r_idle + 16'd1 : r_idle;
                    if (idle_v >= limit) begin
                        n_open      = 1'b0;
                        n_wofs      = '0;
                        n_active    = 1'b0;
                        n_left      = '0;
                        n_dropping  = 1'b0;
                        n_idle      = '0;
                        o_op.status = frt_pkg::ST_TIMEOUT;
                    end else begin
                        n_idle = idle_v;
                    end
                end
            end
            frt_pkg::KIND_READ: begin
                o_op.status = frt_pkg::ST_READ;
                o_op.len    = 9'(r_clen);
                o_op.addr   = frt_pkg::ADDR_W'(i_in.read_index);
                o_op.rd_en  = (32'(i_in.read_index) < 32'(r_clen)) &&
                              (32'(i_in.read_index) < frt_pkg::BUFFER_BYTES);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_dropping <= 1'b0;
            r_drop_ovf <= 1'b0;
            r_active   <= 1'b0;
            r_left     <= '0;
            r_wofs     <= '0;
            r_idle     <= '0;
            r_clen     <= '0;
            r_timeout  <= frt_pkg::TIMEOUT_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (accept) begin
                r_open     <= n_open;
                r_dropping <= n_dropping;
                r_drop_ovf <= n_drop_ovf;
                r_active   <= n_active;
                r_left     <= n_left;
                r_wofs     <= n_wofs;
                r_idle     <= n_idle;
                r_clen     <= n_clen;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/frt_queue.sv
`default_nettype none

module frt_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire frt_pkg::t_q_ctl i_ctl,
    input  wire frt_pkg::t_op   i_op,
    output logic                o_full,
    output logic                o_valid,
    output frt_pkg::t_op        o_op
);

    frt_pkg::t_op                  r_slot [frt_pkg::QUEUE_DEPTH];
    logic [frt_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [frt_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [frt_pkg::QCNT_W-1:0]    r_count;

    assign o_full  = (32'(r_count) == frt_pkg::QUEUE_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_op    = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_slot[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_ctl.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_ctl.pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_ctl.push && !i_ctl.pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_ctl.pop && !i_ctl.push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/frt_back.sv
`default_nettype none

module frt_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire frt_pkg::t_op   i_op,
    output logic                o_pop,
    frt_out_if.source           o_out
);

    logic [7:0]       r_buf [frt_pkg::BUFFER_BYTES];
    logic [7:0]       r_rd_data;
    logic             r_rd_zero;
    logic             r_out_valid;
    frt_pkg::t_status r_status;
    logic [8:0]       r_len;

    assign o_pop = i_valid && (!r_out_valid || o_out.ready);

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_status;
    assign o_out.message_length = r_len;
    assign o_out.read_data      = r_rd_zero ? 8'd0 : r_rd_data;

    // The buffer is written and read in queue order, so a read sees every earlier write.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_op.we) begin
            r_buf[i_op.addr] <= i_op.data;
        end
        if (o_pop) begin
            r_rd_data <= r_buf[i_op.addr];
            r_rd_zero <= !i_op.rd_en;
            r_status  <= i_op.status;
            r_len     <= i_op.len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### rtl/fragment_reassembler_with_timeout.sv
// A result beat passes through the queue slot and the buffer stage's output registers.
// Throughput: one item per cycle while output is ready, set by the single buffer port.
// A two-entry queue between classifier and buffer stage lets either side stall alone.
// Reset is synchronous and active low; it clears all control state and sets the
// timeout to 1000 ticks. The message buffer is not cleared and needs no clearing pass.
`default_nettype none

module fragment_reassembler_with_timeout (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    frt_in_if.sink           i_in,
    frt_out_if.source        o_out
);

    frt_pkg::t_op    front_op;
    frt_pkg::t_op    queue_op;
    frt_pkg::t_q_ctl q_ctl;
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_valid;

    assign q_ctl.push = q_push;
    assign q_ctl.pop  = q_pop;

    frt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_op          (front_op)
    );

    frt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (q_ctl),
        .i_op    (front_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (queue_op)
    );

    frt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_op    (queue_op),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

### rtl/frt_checker.sv
`default_nettype none
`include "assert_macros.svh"

module frt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [2:0] i_out_status,
    input wire logic [8:0] i_out_length,
    input wire logic [7:0] i_out_data
);

    logic status_has_len;

    assign status_has_len = (i_out_status == frt_pkg::ST_COMPLETE) ||
                            (i_out_status == frt_pkg::ST_READ);

    `ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_status) && $stable(i_out_length) && $stable(i_out_data))
    `ASSERT_IMPLIES(a_len_only_done, i_out_valid && !status_has_len, i_out_length == 9'd0)
    `ASSERT_IMPLIES(a_data_only_read, i_out_valid && (i_out_status != frt_pkg::ST_READ), i_out_data == 8'd0)
    `ASSERT_IMPLIES(a_data_in_range, i_out_valid && (i_out_data != 8'd0), i_out_length != 9'd0)

endmodule

bind fragment_reassembler_with_timeout frt_checker u_frt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_length (o_out.message_length),
    .i_out_data   (o_out.read_data)
);

`default_nettype wire

### tb/sv/fragment_reassembler_with_timeout_tb.sv
`timescale 1ns / 100ps

module fragment_reassembler_with_timeout_tb;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 6;
    localparam int STALL_LIMIT = 2000;

    typedef struct packed {
        logic [1:0] kind;
        logic       first_mark;
        logic       last_mark;
        logic       head;
        logic       tail;
        logic [4:0] nbytes;
        logic [7:0] data;
        logic [7:0] rd_idx;
    } t_frag_item;

    typedef struct packed {
        logic [2:0] status;
        logic [8:0] length;
        logic [7:0] data;
    } t_result;

    class reassembly_scoreboard;
        logic [7:0]  msg_bytes [frt_pkg::BUFFER_BYTES];
        int unsigned wr_ofs;
        int unsigned frag_left;
        int unsigned idle_ticks;
        int unsigned completed_len;
        bit          msg_open;
        bit          dropping;
        bit          drop_overflow;
        bit          frag_active;
        logic [15:0] timeout;
        t_result     awaited_results [$];
        int          errors;

        function new();
            wr_ofs = 0;
            frag_left = 0;
            idle_ticks = 0;
            completed_len = 0;
            msg_open = 0;
            dropping = 0;
            drop_overflow = 0;
            frag_active = 0;
            timeout = frt_pkg::TIMEOUT_RESET;
            errors = 0;
        endfunction

        function void set_timeout(logic [15:0] ticks);
            timeout = ticks;
        endfunction

        function t_result reassemble(t_frag_item it);
            t_result     r;
            bit          leak;
            int unsigned limit;
            r = '{frt_pkg::ST_IDLE, 9'd0, 8'd0};
            leak = 0;
            case (it.kind)
                frt_pkg::KIND_BYTE: begin
                    if (it.first_mark) begin
                        frag_active = 0;
                        dropping = 0;
                        if (it.head) begin
                            leak = msg_open;
                            msg_open = 1;
                            wr_ofs = 0;
                            idle_ticks = 0;
                        end
                        if (!msg_open || it.nbytes > frt_pkg::FRAGMENT_MAX_BYTES ||
                            wr_ofs + it.nbytes > frt_pkg::BUFFER_BYTES) begin
                            drop_overflow = msg_open;
                            dropping = !it.last_mark;
                            r.status = msg_open ? frt_pkg::ST_OVERFLOW : frt_pkg::ST_NO_OPEN;
                            return r;
                        end
                        frag_active = 1;
                        frag_left = it.nbytes;
                    end else if (dropping) begin
                        if (it.last_mark) dropping = 0;
                        r.status = drop_overflow ? frt_pkg::ST_OVERFLOW : frt_pkg::ST_NO_OPEN;
                        return r;
                    end else if (!frag_active) begin
                        r.status = frt_pkg::ST_NO_OPEN;
                        return r;
                    end
                    if (frag_left > 0 && wr_ofs < frt_pkg::BUFFER_BYTES) begin
                        msg_bytes[wr_ofs] = it.data;
                        wr_ofs++;
                        frag_left--;
                    end
                    idle_ticks = 0;
                    r.status = leak ? frt_pkg::ST_LEAK : frt_pkg::ST_STORED;
                    if (it.last_mark) begin
                        frag_active = 0;
                        frag_left = 0;
                        if (it.tail) begin
                            completed_len = wr_ofs;
                            msg_open = 0;
                            wr_ofs = 0;
                            r.status = frt_pkg::ST_COMPLETE;
                            r.length = 9'(completed_len);
                        end
                    end
                end
                frt_pkg::KIND_TICK: begin
                    limit = (timeout == 16'd0) ? 1 : timeout;
                    if (msg_open) begin
                        if (idle_ticks < 16'hFFFF) idle_ticks++;
                        if (idle_ticks >= limit) begin
                            msg_open = 0;
                            wr_ofs = 0;
                            frag_active = 0;
                            frag_left = 0;
                            dropping = 0;
                            idle_ticks = 0;
                            r.status = frt_pkg::ST_TIMEOUT;
                        end
                    end
                end
                frt_pkg::KIND_READ: begin
                    r.status = frt_pkg::ST_READ;
                    r.length = 9'(completed_len);
                    if (it.rd_idx < completed_len) r.data = msg_bytes[it.rd_idx];
                end
                default: r.status = frt_pkg::ST_IDLE;
            endcase
            return r;
        endfunction

        function void note_input(t_frag_item it);
            awaited_results.push_back(reassemble(it));
        endfunction

        task report(string what);
            errors++;
            $display("mismatch: %s", what);
        endtask

        task check_result(t_result got);
            t_result want;
            if (awaited_results.size() == 0) begin
                report($sformatf("unexpected result with status %0d", got.status));
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, expected %0d", got.status, want.status));
            if (got.length !== want.length)
                report($sformatf("message_length %0d, expected %0d", got.length, want.length));
            if (got.data !== want.data)
                report($sformatf("read_data %0d, expected %0d", got.data, want.data));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    frt_in_if  in_if ();
    frt_out_if out_if ();

    fragment_reassembler_with_timeout dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    reassembly_scoreboard sb;
    bit calm = 0;
    int gap_pct = 0;
    int items_sent = 0;
    int quiet_cycles = 0;

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic t_frag_item noise_item(logic [1:0] kind);
        t_frag_item it;
        it.kind = kind;
        it.first_mark = 1'($urandom_range(0, 1));
        it.last_mark = 1'($urandom_range(0, 1));
        it.head = 1'($urandom_range(0, 1));
        it.tail = 1'($urandom_range(0, 1));
        it.nbytes = 5'($urandom_range(0, 31));
        it.data = 8'($urandom_range(0, 255));
        it.rd_idx = 8'($urandom_range(0, 255));
        return it;
    endfunction

    task automatic send(t_frag_item it);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.kind <= it.kind;
        in_if.frag_first <= it.first_mark;
        in_if.frag_final <= it.last_mark;
        in_if.head_flag <= it.head;
        in_if.tail_flag <= it.tail;
        in_if.frag_bytes <= it.nbytes;
        in_if.data_byte <= it.data;
        in_if.read_index <= it.rd_idx;
        do @(posedge clk); while (in_if.ready !== 1'b1);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic send_tick();
        send(noise_item(frt_pkg::KIND_TICK));
    endtask

    task automatic send_read(logic [7:0] idx);
        t_frag_item it;
        it = noise_item(frt_pkg::KIND_READ);
        it.rd_idx = idx;
        send(it);
    endtask

    task automatic send_fragment(bit head, bit tail, int nbytes, int beats, int tick_pct);
        t_frag_item it;
        for (int i = 0; i < beats; i++) begin
            if (tick_pct != 0 && $urandom_range(0, 99) < tick_pct) send_tick();
            it = noise_item(frt_pkg::KIND_BYTE);
            it.first_mark = (i == 0);
            it.last_mark = (i == beats - 1);
            if (i == 0) begin
                it.head = head;
                it.nbytes = 5'(nbytes);
            end
            if (i == beats - 1) it.tail = tail;
            send(it);
        end
    endtask

    function automatic logic [7:0] pick_index();
        if (sb.completed_len > 0 && $urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, sb.completed_len - 1));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_message(int tick_pct);
        int frags;
        int nb;
        int beats;
        bit head;
        bit tail;
        frags = $urandom_range(1, 4);
        for (int f = 0; f < frags; f++) begin
            nb = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 31) : $urandom_range(0, 16);
            if ($urandom_range(0, 9) == 0) beats = $urandom_range(1, nb + 3);
            else beats = (nb == 0) ? 1 : nb;
            head = (f == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 19) == 0);
            tail = (f == frags - 1) ? ($urandom_range(0, 9) != 0) : 1'b0;
            send_fragment(head, tail, nb, beats, tick_pct);
        end
        repeat ($urandom_range(0, 3)) send_read(pick_index());
    endtask

    task automatic send_noise(int tick_pct);
        case ($urandom_range(0, 4))
            0: send(noise_item(frt_pkg::KIND_BYTE));
            1: send_tick();
            2: send_read(8'($urandom_range(0, 255)));
            3: send(noise_item(KIND_UNUSED));
            default: send_fragment($urandom_range(0, 1), $urandom_range(0, 1),
                                   $urandom_range(0, 31), $urandom_range(1, 4), tick_pct);
        endcase
    endtask

    // Fills the buffer to its very end, with drops both short of and at the full size.
    task automatic send_long_message();
        send_fragment(1, 0, 16, 16, 0);
        repeat (14) send_fragment(0, 0, 16, 16, 0);
        send_fragment(0, 0, 10, 10, 0);
        send_fragment(0, 1, 10, 10, 0);
        send_fragment(0, 0, 6, 6, 0);
        send_fragment(0, 1, 1, 1, 0);
        send_fragment(0, 1, 0, 1, 0);
        send_read(8'd255);
        send_read(8'd0);
        send_read(pick_index());
    endtask

    task automatic run_random(int target, int tick_pct);
        while (items_sent < target) begin
            if ($urandom_range(0, 4) == 0) send_noise(tick_pct);
            else send_message(tick_pct);
        end
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (sb.awaited_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(logic [15:0] ticks);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= ticks;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_timeout(ticks);
    endtask

    initial begin
        t_frag_item stray;
        sb = new();
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 16'd0;
        in_if.valid <= 1'b0;
        in_if.kind <= frt_pkg::KIND_BYTE;
        in_if.frag_first <= 1'b0;
        in_if.frag_final <= 1'b0;
        in_if.head_flag <= 1'b0;
        in_if.tail_flag <= 1'b0;
        in_if.frag_bytes <= 5'd0;
        in_if.data_byte <= 8'd0;
        in_if.read_index <= 8'd0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        send_read(8'd0);
        send_tick();
        send(noise_item(KIND_UNUSED));
        stray = noise_item(frt_pkg::KIND_BYTE);
        stray.first_mark = 1'b0;
        send(stray);
        send_fragment(0, 0, 2, 2, 0);
        send_fragment(1, 0, 2, 2, 0);
        send_fragment(1, 0, 1, 1, 0);
        send_fragment(0, 1, 17, 1, 0);
        send_fragment(0, 0, 31, 2, 0);
        send_fragment(0, 1, 0, 1, 0);
        send_read(8'd0);
        send_read(8'd255);
        send_fragment(1, 1, 2, 4, 0);
        send_fragment(1, 1, 3, 1, 0);
        send_fragment(1, 0, 4, 2, 0);
        send_fragment(0, 1, 1, 1, 0);
        send_fragment(1, 0, 1, 1, 0);
        send_fragment(1, 1, 1, 1, 0);

        write_timeout(16'd1);
        gap_pct = 8;
        run_random(140, 5);
        write_timeout(16'd0);
        gap_pct = 25;
        run_random(220, 5);
        write_timeout(16'd3);
        gap_pct = 0;
        run_random(320, 15);
        write_timeout(16'hFFFF);
        gap_pct = 8;
        send_long_message();
        run_random(620, 10);
        write_timeout(16'($urandom_range(2, 8)));
        gap_pct = 25;
        run_random(690, 20);
        calm = 1;
        gap_pct = 0;
        run_random(760, 20);

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        out_if.ready <= 1'b0;
        @(posedge clk);
        forever begin
            repeat ($urandom_range(1, 40)) begin
                out_if.ready <= 1'b1;
                @(posedge clk);
            end
            if (!calm) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin : result_monitor
        t_result got;
        if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            got.status = out_if.status;
            got.length = out_if.message_length;
            got.data = out_if.read_data;
            sb.check_result(got);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
            (out_if.valid === 1'b1 && out_if.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
